### rtl/bnc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnc_pkg
// Shared types and constants of the brace nesting checker: limits, request and
// state structs, lexer mode codes, status codes and character codes.
// ----------------------------------------------------------------------------
package bnc_pkg;

  // Limits
  localparam int MAX_DEPTH  = 127;
  localparam int COUNT_BITS = 16;
  localparam int DEPTH_BITS = 8;

  // Characters the lexer reacts to
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_OPEN   = 8'h7b;
  localparam logic [7:0] CH_CLOSE  = 8'h7d;

  // Status codes reported with the last byte
  typedef enum logic [1:0] {
    STATUS_BALANCED   = 2'd0,
    STATUS_UNBALANCED = 2'd1,
    STATUS_PREMATURE  = 2'd2
  } status_t;

  // Lexer modes
  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESCAPE  = 3'd1,
    MODE_SQUOTE  = 3'd2,
    MODE_DQUOTE  = 3'd3,
    MODE_SLASH   = 3'd4,
    MODE_COMMENT = 3'd5,
    MODE_STAR    = 3'd6
  } lex_mode_t;

  // One source byte
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } byte_req_t;

  // One result
  typedef struct packed {
    logic signed [DEPTH_BITS-1:0] depth;
    logic                         routine_closed;
    logic [COUNT_BITS-1:0]        routine_count;
    logic                         finished;
    logic [1:0]                   status;
  } result_req_t;

  // Running checker state
  typedef struct packed {
    lex_mode_t                    mode;
    logic signed [DEPTH_BITS-1:0] level;
    logic [COUNT_BITS-1:0]        count;
  } scan_state_t;

endpackage

### rtl/bnc_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnc_in_reg
// Input register: captures one byte request and holds it until the result
// register downstream can take the processed result.
// ----------------------------------------------------------------------------
module bnc_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  bnc_pkg::byte_req_t byte_req,
  output logic               held_valid,
  output bnc_pkg::byte_req_t held_req,
  input  logic               advance
);
  import bnc_pkg::*;

  logic load;

  // Room when empty or when the held request moves on this cycle
  assign byte_stall = held_valid && !advance;
  assign load       = byte_valid && !byte_stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      held_req <= byte_req;
    end
  end

endmodule

### rtl/bnc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnc_step
// Lexer and nesting step: given the current state and one byte, produces the
// next state and the result fields for that byte.
// ----------------------------------------------------------------------------
module bnc_step (
  input  bnc_pkg::scan_state_t state,
  input  bnc_pkg::byte_req_t   req,
  output bnc_pkg::scan_state_t state_next,
  output bnc_pkg::result_req_t result
);
  import bnc_pkg::*;

  localparam logic signed [DEPTH_BITS-1:0] LEVEL_TOP = DEPTH_BITS'(MAX_DEPTH);
  localparam logic signed [DEPTH_BITS-1:0] LEVEL_BOT = DEPTH_BITS'(-MAX_DEPTH);

  lex_mode_t                    mode_next;
  logic signed [DEPTH_BITS-1:0] level_next;
  logic [COUNT_BITS-1:0]        count_next;
  logic                         closed;
  status_t                      status;

  // Mode transitions and brace counting
  always_comb begin
    mode_next  = state.mode;
    level_next = state.level;
    count_next = state.count;
    closed     = 1'b0;
    unique case (state.mode)
      MODE_NORMAL: begin
        if (req.ch == CH_BSLASH) begin
          mode_next = MODE_ESCAPE;
        end else if (req.ch == CH_SQUOTE) begin
          mode_next = MODE_SQUOTE;
        end else if (req.ch == CH_DQUOTE) begin
          mode_next = MODE_DQUOTE;
        end else if (req.ch == CH_SLASH) begin
          mode_next = MODE_SLASH;
        end else if (req.ch == CH_OPEN) begin
          if (state.level < LEVEL_TOP) begin
            level_next = state.level + DEPTH_BITS'(1);
          end
        end else if (req.ch == CH_CLOSE) begin
          if (state.level > LEVEL_BOT) begin
            level_next = state.level - DEPTH_BITS'(1);
            // Dropping from one to zero closes a routine
            if (state.level == DEPTH_BITS'(1)) begin
              closed = 1'b1;
              if (!(&state.count)) begin
                count_next = state.count + COUNT_BITS'(1);
              end
            end
          end
        end
      end
      MODE_ESCAPE: mode_next = MODE_NORMAL;
      MODE_SQUOTE: begin
        if (req.ch == CH_SQUOTE) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_DQUOTE: begin
        if (req.ch == CH_DQUOTE) begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_SLASH: mode_next = (req.ch == CH_STAR) ? MODE_COMMENT : MODE_NORMAL;
      MODE_COMMENT: begin
        if (req.ch == CH_STAR) begin
          mode_next = MODE_STAR;
        end
      end
      MODE_STAR: mode_next = (req.ch == CH_SLASH) ? MODE_NORMAL : MODE_COMMENT;
      default: mode_next = MODE_NORMAL;
    endcase
  end

  // End of file status
  always_comb begin
    status = STATUS_BALANCED;
    if (req.last) begin
      if (mode_next != MODE_NORMAL) begin
        status = STATUS_PREMATURE;
      end else if (level_next != '0) begin
        status = STATUS_UNBALANCED;
      end
    end
  end

  // Result fields; state starts over after the last byte
  always_comb begin
    result.depth          = level_next;
    result.routine_closed = closed;
    result.routine_count  = count_next;
    result.finished       = req.last;
    result.status         = status;
    if (req.last) begin
      state_next.mode  = MODE_NORMAL;
      state_next.level = '0;
      state_next.count = '0;
    end else begin
      state_next.mode  = mode_next;
      state_next.level = level_next;
      state_next.count = count_next;
    end
  end

endmodule

### rtl/brace_nesting_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brace_nesting_checker
// Tracks the brace nesting level of C source fed one byte per request and
// reports the level, closed routines and an end of file status.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel  : byte_valid / byte_stall / byte_req {ch, last}. A request
//                   is taken at a clock edge with valid high and stall low.
//   result channel: result_valid / result_stall / result_req, one result per
//                   byte, in order. status is meaningful when finished is set.
//   Pipeline: two register stages, the input register, then the result register.
//   Throughput: one byte per cycle while result_stall is low; the lexer
//   state, level and count are computed combinationally from the input
//   register and loaded into the result register.
//   Stall: with the result register full and stalled, the input register
//   still takes one more byte, then byte_stall rises until results drain.
//   Nothing is lost or repeated while stalled.
//   Reset (rst, synchronous): clears both stages and returns the lexer to
//   normal mode with level and count at zero. The byte marked last also
//   returns the state to its reset values, so the next byte starts a new file.
// ----------------------------------------------------------------------------
module brace_nesting_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  bnc_pkg::byte_req_t   byte_req,
  output logic                 result_valid,
  input  logic                 result_stall,
  output bnc_pkg::result_req_t result_req
);
  import bnc_pkg::*;

  logic         held_valid;
  byte_req_t    held_req;
  logic         advance;
  scan_state_t  state;
  scan_state_t  state_next;
  result_req_t  step_result;

  // Move the held byte on when the result register is free or draining
  assign advance = held_valid && (!result_valid || !result_stall);

  bnc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_req   (byte_req),
    .held_valid (held_valid),
    .held_req   (held_req),
    .advance    (advance)
  );

  bnc_step u_step (
    .state      (state),
    .req        (held_req),
    .state_next (state_next),
    .result     (step_result)
  );

  // Scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode  <= MODE_NORMAL;
      state.level <= '0;
      state.count <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      result_req <= step_result;
    end
  end

endmodule
